// File: rtl/asc_pkg.sv
package asc_pkg;

    localparam int NUM_SIGS = 10;
    localparam int SIG_MAX  = 16;

    // Bit 8 set marks a wildcard position that matches any byte.
    localparam logic [8:0] ANY = 9'h100;

    localparam logic [1:0] CLASS_UNKNOWN  = 2'd0;
    localparam logic [1:0] CLASS_LOSSY    = 2'd1;
    localparam logic [1:0] CLASS_LOSSLESS = 2'd2;

    localparam logic [3:0] NO_MATCH = 4'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_header;
    } t_in_item;

    typedef struct packed {
        logic [1:0] file_class;
        logic [3:0] matched_format;
    } t_out_item;

    localparam logic [4:0] SIG_LEN [0:NUM_SIGS-1] = '{
        5'd2, 5'd5, 5'd2, 5'd2, 5'd4, 5'd16, 5'd12, 5'd4, 5'd4, 5'd12
    };

    localparam logic [1:0] SIG_CLASS [0:NUM_SIGS-1] = '{
        CLASS_LOSSY, CLASS_LOSSY, CLASS_LOSSY, CLASS_LOSSY, CLASS_LOSSY,
        CLASS_LOSSY, CLASS_LOSSLESS, CLASS_LOSSLESS, CLASS_LOSSLESS, CLASS_LOSSLESS
    };

    // Positions past a signature's length are never compared; pad with wildcards.
    localparam logic [8:0] SIG_BYTES [0:NUM_SIGS-1][0:SIG_MAX-1] = '{
        '{9'h00B, 9'h077, ANY, ANY, ANY, ANY, ANY, ANY,
          ANY, ANY, ANY, ANY, ANY, ANY, ANY, ANY},
        '{9'h023, 9'h021, 9'h041, 9'h04D, 9'h052, ANY, ANY, ANY,
          ANY, ANY, ANY, ANY, ANY, ANY, ANY, ANY},
        '{9'h0FF, 9'h0FD, ANY, ANY, ANY, ANY, ANY, ANY,
          ANY, ANY, ANY, ANY, ANY, ANY, ANY, ANY},
        '{9'h0FF, 9'h0FB, ANY, ANY, ANY, ANY, ANY, ANY,
          ANY, ANY, ANY, ANY, ANY, ANY, ANY, ANY},
        '{9'h04F, 9'h067, 9'h067, 9'h053, ANY, ANY, ANY, ANY,
          ANY, ANY, ANY, ANY, ANY, ANY, ANY, ANY},
        '{9'h030, 9'h026, 9'h0B2, 9'h075, 9'h08E, 9'h066, 9'h0CF, 9'h011,
          9'h0A6, 9'h0D9, 9'h000, 9'h0AA, 9'h000, 9'h062, 9'h0CE, 9'h06C},
        '{9'h046, 9'h04F, 9'h052, 9'h04D, ANY, ANY, ANY, ANY,
          9'h041, 9'h049, 9'h046, 9'h046, ANY, ANY, ANY, ANY},
        '{9'h066, 9'h04C, 9'h061, 9'h043, ANY, ANY, ANY, ANY,
          ANY, ANY, ANY, ANY, ANY, ANY, ANY, ANY},
        '{9'h054, 9'h054, 9'h041, 9'h031, ANY, ANY, ANY, ANY,
          ANY, ANY, ANY, ANY, ANY, ANY, ANY, ANY},
        '{9'h052, 9'h049, 9'h046, 9'h046, ANY, ANY, ANY, ANY,
          9'h057, 9'h041, 9'h056, 9'h045, ANY, ANY, ANY, ANY}
    };

endpackage

// File: rtl/asc_match.sv
module asc_match import asc_pkg::*; #(
    parameter int POS_W = 6
) (
    input  logic [7:0]          i_data_byte,
    input  logic [POS_W-1:0]    i_position,
    input  logic [NUM_SIGS-1:0] i_alive,
    output logic [NUM_SIGS-1:0] o_alive
);

    // Compare the byte against every signature at once; drop those that miss.
    always_comb begin
        logic [8:0] want;
        logic       in_range;
        for (int i = 0; i < NUM_SIGS; i++) begin
            in_range   = i_position < POS_W'(SIG_LEN[i]);
            want       = SIG_BYTES[i][i_position[3:0]];
            o_alive[i] = i_alive[i]
                       & ~(in_range & ~want[8] & (want[7:0] != i_data_byte));
        end
    end

endmodule

// File: rtl/asc_select.sv
module asc_select import asc_pkg::*; #(
    parameter int POS_W = 6
) (
    input  logic [NUM_SIGS-1:0] i_alive,
    input  logic [POS_W-1:0]    i_position,
    output t_out_item           o_result
);

    always_comb begin
        logic found;
        found                   = 1'b0;
        o_result.file_class     = CLASS_UNKNOWN;
        o_result.matched_format = NO_MATCH;
        for (int i = 0; i < NUM_SIGS; i++) begin
            if (!found && i_alive[i] && (POS_W'(SIG_LEN[i]) <= i_position)) begin
                found                   = 1'b1;
                o_result.file_class     = SIG_CLASS[i];
                o_result.matched_format = 4'(i);
            end
        end
    end

endmodule

// File: rtl/audio_signature_classifier.sv
// An end-of-header byte is held in the input register, then its result is registered.
// Throughput: one byte per cycle unless stalled; each byte costs one pass through the
//   signature compare array between the input register and the state/result registers.
// A stalled result holds the result register; an end-of-header input then backs up.
// Reset (synchronous, active low) empties both registers, sets all alive flags and
//   clears the byte counter; the state returns to that point after every result.
module audio_signature_classifier import asc_pkg::*; #(
    parameter int HEADER_BYTES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Counter must hold HEADER_BYTES itself, where it saturates.
    localparam int POS_W = $clog2(HEADER_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(HEADER_BYTES);

    // Input register: one buffered transaction.
    logic      r_in_valid;
    t_in_item  r_in;

    // Matching state for the file in progress.
    logic [NUM_SIGS-1:0] r_alive;
    logic [POS_W-1:0]    r_pos;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    logic                out_free;
    logic                proc;
    logic                take_in;
    logic                counting;
    logic [NUM_SIGS-1:0] match_alive;
    logic [NUM_SIGS-1:0] n_alive;
    logic [POS_W-1:0]    n_pos;
    t_out_item           sel_result;

    // The result slot frees when it is empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    // Process the buffered byte unless it needs the result slot and that is full.
    assign proc    = r_in_valid && (!r_in.end_of_header || out_free);
    assign take_in = i_in_valid && !o_in_stall;

    // Hold new input only while the buffered byte cannot advance.
    assign o_in_stall = r_in_valid && !proc;

    asc_match #(
        .POS_W(POS_W)
    ) u_match (
        .i_data_byte (r_in.data_byte),
        .i_position  (r_pos),
        .i_alive     (r_alive),
        .o_alive     (match_alive)
    );

    // Bytes beyond the header window leave the state untouched.
    assign counting = r_pos < POS_MAX;
    assign n_alive  = counting ? match_alive : r_alive;
    assign n_pos    = counting ? r_pos + 1'b1 : r_pos;

    // Pick the winner from the state as it stands after this byte.
    asc_select #(
        .POS_W(POS_W)
    ) u_select (
        .i_alive    (n_alive),
        .i_position (n_pos),
        .o_result   (sel_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_alive     <= '1;
            r_pos       <= '0;
        end else begin
            // Advance the input register.
            if (take_in) begin
                r_in_valid <= 1'b1;
                r_in       <= i_in_data;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end

            // Update the matching state; rearm it once a file's result is issued.
            if (proc) begin
                if (r_in.end_of_header) begin
                    r_alive <= '1;
                    r_pos   <= '0;
                end else begin
                    r_alive <= n_alive;
                    r_pos   <= n_pos;
                end
            end

            // Load a new result or drop the one just taken.
            if (proc && r_in.end_of_header) begin
                r_out_valid <= 1'b1;
                r_out       <= sel_result;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Counter never runs past the header window.
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("byte counter beyond header window");

    // A finished file leaves the state rearmed.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.end_of_header |=> (r_pos == '0) && (r_alive == '1))
        else $error("state not rearmed after result");

    // "No match" and "unknown class" always come together.
    a_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.matched_format == NO_MATCH)
                         == (r_out.file_class == CLASS_UNKNOWN)))
        else $error("class and format disagree");

    // A result is never overwritten while it waits.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !(proc && r_in.end_of_header))
        else $error("pending result overwritten");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import asc_pkg::*;

    // Signature order doubles as report priority: a lower index wins.
    typedef enum logic [3:0] {
        FMT_AC3, FMT_AMR, FMT_MP2, FMT_MP3, FMT_OGG,
        FMT_WMA, FMT_AIFF, FMT_FLAC, FMT_TTA, FMT_WAV
    } t_format;

    localparam int HDR_LIMIT    = 32;
    localparam int MAGIC_COUNT  = 10;
    localparam int MAGIC_DEPTH  = 16;
    localparam int RAND_ITEMS   = 1275;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 150;
    localparam int SEND_CALM_LO = 400;
    localparam int SEND_CALM_HI = 700;
    localparam int RECV_CALM_LO = 700;
    localparam int RECV_CALM_HI = 1100;

    // Bit 8 marks a position that accepts any byte.
    localparam logic [8:0] WILD = 9'h100;

    localparam int MAGIC_LEN [MAGIC_COUNT] = '{2, 5, 2, 2, 4, 16, 12, 4, 4, 12};

    localparam logic [1:0] MAGIC_KIND [MAGIC_COUNT] = '{
        CLASS_LOSSY, CLASS_LOSSY, CLASS_LOSSY, CLASS_LOSSY, CLASS_LOSSY,
        CLASS_LOSSY, CLASS_LOSSLESS, CLASS_LOSSLESS, CLASS_LOSSLESS, CLASS_LOSSLESS
    };

    localparam logic [8:0] MAGIC_BYTES [MAGIC_COUNT][MAGIC_DEPTH] = '{
        '{9'h0B, 9'h77, WILD, WILD, WILD, WILD, WILD, WILD,
          WILD, WILD, WILD, WILD, WILD, WILD, WILD, WILD},
        '{9'h23, 9'h21, 9'h41, 9'h4D, 9'h52, WILD, WILD, WILD,
          WILD, WILD, WILD, WILD, WILD, WILD, WILD, WILD},
        '{9'hFF, 9'hFD, WILD, WILD, WILD, WILD, WILD, WILD,
          WILD, WILD, WILD, WILD, WILD, WILD, WILD, WILD},
        '{9'hFF, 9'hFB, WILD, WILD, WILD, WILD, WILD, WILD,
          WILD, WILD, WILD, WILD, WILD, WILD, WILD, WILD},
        '{9'h4F, 9'h67, 9'h67, 9'h53, WILD, WILD, WILD, WILD,
          WILD, WILD, WILD, WILD, WILD, WILD, WILD, WILD},
        '{9'h30, 9'h26, 9'hB2, 9'h75, 9'h8E, 9'h66, 9'hCF, 9'h11,
          9'hA6, 9'hD9, 9'h00, 9'hAA, 9'h00, 9'h62, 9'hCE, 9'h6C},
        '{9'h46, 9'h4F, 9'h52, 9'h4D, WILD, WILD, WILD, WILD,
          9'h41, 9'h49, 9'h46, 9'h46, WILD, WILD, WILD, WILD},
        '{9'h66, 9'h4C, 9'h61, 9'h43, WILD, WILD, WILD, WILD,
          WILD, WILD, WILD, WILD, WILD, WILD, WILD, WILD},
        '{9'h54, 9'h54, 9'h41, 9'h31, WILD, WILD, WILD, WILD,
          WILD, WILD, WILD, WILD, WILD, WILD, WILD, WILD},
        '{9'h52, 9'h49, 9'h46, 9'h46, WILD, WILD, WILD, WILD,
          9'h57, 9'h41, 9'h56, 9'h45, WILD, WILD, WILD, WILD}
    };

    localparam t_out_item NONE_FOUND = '{CLASS_UNKNOWN, NO_MATCH};

    // One directed transaction: the byte, its end flag, and an expected verdict
    // that is used instead of the predictor's when typed is set.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       eoh;
        logic       typed;
        t_out_item  want;
    } t_row;

    localparam int DIR_ROWS = 25;

    localparam t_row DIRECTED [DIR_ROWS] = '{
        // lone bytes right after reset: the extremes, both too short for anything
        '{8'h00, 1'b1, 1'b1, NONE_FOUND},
        '{8'hFF, 1'b1, 1'b1, NONE_FOUND},
        // AC3
        '{8'h0B, 1'b0, 1'b0, NONE_FOUND},
        '{8'h77, 1'b1, 1'b1, '{CLASS_LOSSY, FMT_AC3}},
        // MP2 and MP3 share the leading 0xFF
        '{8'hFF, 1'b0, 1'b0, NONE_FOUND},
        '{8'hFD, 1'b1, 1'b1, '{CLASS_LOSSY, FMT_MP2}},
        '{8'hFF, 1'b0, 1'b0, NONE_FOUND},
        '{8'hFB, 1'b1, 1'b1, '{CLASS_LOSSY, FMT_MP3}},
        // AMR
        '{8'h23, 1'b0, 1'b0, NONE_FOUND},
        '{8'h21, 1'b0, 1'b0, NONE_FOUND},
        '{8'h41, 1'b0, 1'b0, NONE_FOUND},
        '{8'h4D, 1'b0, 1'b0, NONE_FOUND},
        '{8'h52, 1'b1, 1'b1, '{CLASS_LOSSY, FMT_AMR}},
        // Ogg
        '{8'h4F, 1'b0, 1'b0, NONE_FOUND},
        '{8'h67, 1'b0, 1'b0, NONE_FOUND},
        '{8'h67, 1'b0, 1'b0, NONE_FOUND},
        '{8'h53, 1'b1, 1'b0, NONE_FOUND},
        // FLAC
        '{8'h66, 1'b0, 1'b0, NONE_FOUND},
        '{8'h4C, 1'b0, 1'b0, NONE_FOUND},
        '{8'h61, 1'b0, 1'b0, NONE_FOUND},
        '{8'h43, 1'b1, 1'b0, NONE_FOUND},
        // WAV prefix that ends before the signature is complete: no match
        '{8'h52, 1'b0, 1'b0, NONE_FOUND},
        '{8'h49, 1'b0, 1'b0, NONE_FOUND},
        '{8'h46, 1'b0, 1'b0, NONE_FOUND},
        '{8'h46, 1'b1, 1'b1, NONE_FOUND}
    };

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Side channel that travels with the input transaction: a typed verdict.
    logic      drv_typed = 1'b0;
    t_out_item drv_want  = NONE_FOUND;

    // Predictor state.
    logic [MAGIC_COUNT-1:0] sig_alive = '1;
    int                     hdr_count = 0;

    t_out_item   verdict_q [$];
    logic [7:0]  hdr_bytes [$];
    bit   [10:0] outcomes_seen = '0;

    int errors       = 0;
    int items_in     = 0;
    int results_seen = 0;
    int idle_run     = 0;
    int cycle_no     = 0;
    int random_sent  = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    audio_signature_classifier #(
        .HEADER_BYTES (HDR_LIMIT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Advance the predictor by one header byte; report a verdict on the last one.
    task automatic classify_byte(input t_in_item tr, output bit produced,
                                 output t_out_item verdict);
        int s;
        bit found;
        produced = 1'b0;
        found    = 1'b0;
        verdict  = NONE_FOUND;
        // Bytes past the counter limit are dropped without touching the flags.
        if (hdr_count < HDR_LIMIT) begin
            for (s = 0; s < MAGIC_COUNT; s++) begin
                if (hdr_count < MAGIC_LEN[s] && !MAGIC_BYTES[s][hdr_count][8]
                    && MAGIC_BYTES[s][hdr_count][7:0] != tr.data_byte)
                    sig_alive[s] = 1'b0;
            end
            hdr_count++;
        end
        if (tr.end_of_header) begin
            produced = 1'b1;
            // First live signature that fits in the bytes seen wins.
            for (s = 0; s < MAGIC_COUNT; s++) begin
                if (!found && sig_alive[s] && MAGIC_LEN[s] <= hdr_count) begin
                    found                  = 1'b1;
                    verdict.file_class     = MAGIC_KIND[s];
                    verdict.matched_format = 4'(s);
                end
            end
            sig_alive = '1;
            hdr_count = 0;
        end
    endtask

    // Offer one transaction, with random gaps in front; return once it is taken.
    // Call at a falling edge; returns at a falling edge.
    task automatic offer(input t_in_item tr, input logic typed, input t_out_item want);
        bit calm;
        calm = random_sent >= SEND_CALM_LO && random_sent < SEND_CALM_HI;
        while (!calm && $urandom_range(0, 99) < 27) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tr;
        drv_typed  <= typed;
        drv_want   <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Build one random header in hdr_bytes: mostly real signatures with random
    // wildcard bytes and tails, some damaged or cut short, the rest noise.
    task automatic build_header();
        int pick;
        int sig;
        int k;
        int tail;
        int keep;
        pick = $urandom_range(0, 99);
        hdr_bytes.delete();
        if (pick < 72) begin
            sig = $urandom_range(0, MAGIC_COUNT - 1);
            for (k = 0; k < MAGIC_LEN[sig]; k++)
                hdr_bytes.push_back(MAGIC_BYTES[sig][k][8] ? 8'($urandom_range(0, 255))
                                                           : MAGIC_BYTES[sig][k][7:0]);
            // Now and then run well past the counter limit.
            tail = ($urandom_range(0, 9) == 0) ? $urandom_range(HDR_LIMIT, HDR_LIMIT + 12)
                                              : $urandom_range(0, 6);
            repeat (tail) hdr_bytes.push_back(8'($urandom_range(0, 255)));
            if (pick < 12) begin
                k = $urandom_range(0, MAGIC_LEN[sig] - 1);
                hdr_bytes[k] = hdr_bytes[k] ^ 8'($urandom_range(1, 255));
            end else if (pick < 20) begin
                keep = $urandom_range(1, MAGIC_LEN[sig] - 1);
                while (hdr_bytes.size() > keep) void'(hdr_bytes.pop_back());
            end
        end else begin
            tail = (pick < 94) ? $urandom_range(1, 12) : $urandom_range(1, HDR_LIMIT + 8);
            repeat (tail) hdr_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: random stalls, a calm window, and one long hold-off once enough
    // verdicts have passed so that the block backs up into its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (cycle_no >= RECV_CALM_LO && cycle_no < RECV_CALM_HI) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 27);
        end
    end

    // Monitor: predict on each accepted input transaction, check each accepted
    // result against the oldest verdict, and count cycles with no progress.
    always @(posedge i_clk) begin : monitor
        bit        produced;
        t_out_item predicted;
        t_out_item oldest;
        bit        moved;
        moved = 1'b0;
        cycle_no++;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                items_in++;
                classify_byte(i_in_data, produced, predicted);
                if (produced) begin
                    if (drv_typed)
                        predicted = drv_want;
                    verdict_q.push_back(predicted);
                    outcomes_seen[predicted.matched_format] = 1'b1;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                results_seen++;
                if (verdict_q.size() == 0) begin
                    $error("result with no verdict pending: file_class %0d matched_format %0d",
                           o_out_data.file_class, o_out_data.matched_format);
                    errors++;
                end else begin
                    oldest = verdict_q.pop_front();
                    if (o_out_data.file_class !== oldest.file_class) begin
                        $error("file_class: expected %0d, got %0d",
                               oldest.file_class, o_out_data.file_class);
                        errors++;
                    end
                    if (o_out_data.matched_format !== oldest.matched_format) begin
                        $error("matched_format: expected %0d, got %0d",
                               oldest.matched_format, o_out_data.matched_format);
                        errors++;
                    end
                end
            end
        end
        idle_run = moved ? 0 : idle_run + 1;
    end

    initial begin : main
        t_in_item tr;
        int       r;
        int       k;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        fork
            begin
                // Directed table first, then random headers.
                for (r = 0; r < DIR_ROWS; r++) begin
                    tr.data_byte     = DIRECTED[r].byte_val;
                    tr.end_of_header = DIRECTED[r].eoh;
                    offer(tr, DIRECTED[r].typed, DIRECTED[r].want);
                end
                while (random_sent < RAND_ITEMS) begin
                    build_header();
                    for (k = 0; k < hdr_bytes.size(); k++) begin
                        tr.data_byte     = hdr_bytes[k];
                        tr.end_of_header = (k == hdr_bytes.size() - 1);
                        offer(tr, 1'b0, NONE_FOUND);
                        // Ignored bytes past the limit do not count.
                        if (k < HDR_LIMIT)
                            random_sent++;
                    end
                end
                i_in_valid <= 1'b0;
                drv_typed  <= 1'b0;
                while (verdict_q.size() != 0) @(posedge i_clk);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            while (idle_run < STUCK_LIMIT) @(posedge i_clk);
        join_any

        if (idle_run >= STUCK_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_run);
            errors++;
        end
        if (verdict_q.size() != 0) begin
            $error("%0d verdicts never arrived", verdict_q.size());
            errors++;
        end
        $display("Covered %0d header bytes and %0d verdicts, %0d of %0d outcomes,",
                 items_in, results_seen, $countones(outcomes_seen), MAGIC_COUNT + 1);
        $display("with a %0d-cycle output hold-off and %0d errors.", HOLD_CYCLES, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/asc_pkg.sv
rtl/asc_match.sv
rtl/asc_select.sv
rtl/audio_signature_classifier.sv
test/tb.sv
